// ----- src/wblru_pkg.sv -----
// package for the write-back lru set-associative cache
// types, constants and state enums shared by all modules but the ram; no dependencies
`timescale 1ns / 1ps
package wblru_pkg;

  localparam int SETS_DEF           = 4;
  localparam int WAYS_DEF           = 2;
  localparam int WORDS_PER_LINE_DEF = 64;
  localparam int TAGS_PER_SET_DEF   = 16;

  localparam int SET_W  = 2;
  localparam int TAG_W  = 4;
  localparam int OFF_W  = 6;
  localparam int DATA_W = 32;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SET_W-1:0]   set_index;
    logic [TAG_W-1:0]   tag;
    logic [OFF_W-1:0]   word_offset;
    logic signed [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     hit;
    logic                     wrote_back;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WB_RD,
    ST_FILL_RD,
    ST_ACCESS,
    ST_DONE
  } be_state_t;

endpackage

// ----- src/write_back_lru_set_assoc_cache.sv -----
// top level of the write-back lru set-associative cache
// depends on wblru_pkg, wblru_front, wblru_back
`timescale 1ns / 1ps
// a command beat is taken when start is high and busy is low; each command
// gives one result beat, shown for exactly one cycle with done high. the
// receiver cannot stall, so it must take the beat in the cycle done is high.
// after reset the internal backing store is swept to zero, one word a cycle,
// all SETS*TAGS_PER_SET*WORDS_PER_LINE words (4096 by default), with busy high.
// a hit goes through the back end as lookup, ram access, result; on a miss
// the lookup is followed by a copy-out of the victim when it is dirty, then
// the line fill, each word by word, before the ram access and the result.
// a two-beat queue lets the front take commands while the back works.
module write_back_lru_set_assoc_cache #(
  parameter int SETS           = wblru_pkg::SETS_DEF,
  parameter int WAYS           = wblru_pkg::WAYS_DEF,
  parameter int WORDS_PER_LINE = wblru_pkg::WORDS_PER_LINE_DEF,
  parameter int TAGS_PER_SET   = wblru_pkg::TAGS_PER_SET_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  wblru_pkg::req_t req,
  output logic            done,
  output wblru_pkg::rsp_t rsp
);
  logic            full;
  logic            q_valid;
  logic            q_pop;
  logic            be_ready;
  wblru_pkg::req_t q_req;
  logic            cleared;

  // hold off commands during the store clear sweep and when the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      cleared <= 1'b0;
    end else if (be_ready) begin
      cleared <= 1'b1;
    end
  end
  assign busy = full || !cleared;

  wblru_front #(
    .SETS(SETS), .TAGS_PER_SET(TAGS_PER_SET), .WORDS_PER_LINE(WORDS_PER_LINE)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_req(req),
    .full(full), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  wblru_back #(
    .SETS(SETS), .WAYS(WAYS), .WORDS_PER_LINE(WORDS_PER_LINE),
    .TAGS_PER_SET(TAGS_PER_SET)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .ready(be_ready), .done(done), .rsp(rsp)
  );
endmodule

// ----- src/wblru_ram.sv -----
// generic single-port-write, one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module wblru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/wblru_front.sv -----
// front part: takes commands, reduces fields, queues them for the back part
// depends on wblru_pkg
`timescale 1ns / 1ps
module wblru_front #(
  parameter int SETS           = wblru_pkg::SETS_DEF,
  parameter int TAGS_PER_SET   = wblru_pkg::TAGS_PER_SET_DEF,
  parameter int WORDS_PER_LINE = wblru_pkg::WORDS_PER_LINE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  wblru_pkg::req_t in_req,
  output logic            full,
  output logic            q_valid,
  output wblru_pkg::req_t q_req,
  input  logic            q_pop
);
  // two-entry queue
  wblru_pkg::req_t ent [2];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count;
  wblru_pkg::req_t red;

  // modulo reduction of out-of-range fields
  always_comb begin
    red             = in_req;
    red.set_index   = wblru_pkg::SET_W'(32'(in_req.set_index) % SETS);
    red.tag         = wblru_pkg::TAG_W'(32'(in_req.tag) % TAGS_PER_SET);
    red.word_offset = wblru_pkg::OFF_W'(32'(in_req.word_offset) % WORDS_PER_LINE);
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_req   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid) begin
      ent[wr_ptr] <= red;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(in_valid) - 2'(q_pop);
    end
  end
endmodule

// ----- src/wblru_back.sv -----
// back part: store clear, tag lookup, victim write-back, line fill, access and lru update
// depends on wblru_pkg and wblru_ram
`timescale 1ns / 1ps
module wblru_back #(
  parameter int SETS           = wblru_pkg::SETS_DEF,
  parameter int WAYS           = wblru_pkg::WAYS_DEF,
  parameter int WORDS_PER_LINE = wblru_pkg::WORDS_PER_LINE_DEF,
  parameter int TAGS_PER_SET   = wblru_pkg::TAGS_PER_SET_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  wblru_pkg::req_t q_req,
  output logic            q_pop,
  output logic            ready,
  output logic            done,
  output wblru_pkg::rsp_t rsp
);
  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int OW    = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int TW    = (TAGS_PER_SET > 1) ? $clog2(TAGS_PER_SET) : 1;
  localparam int NL    = SETS * WAYS;
  localparam int NR    = SETS * TAGS_PER_SET;
  localparam int CDEP  = NL * WORDS_PER_LINE;
  localparam int BDEP  = NR * WORDS_PER_LINE;
  localparam int CAW   = $clog2(CDEP);
  localparam int BAW   = $clog2(BDEP);
  localparam int LW    = $clog2(NL);
  localparam int RW    = $clog2(NR);
  localparam int DW    = wblru_pkg::DATA_W;

  wblru_pkg::be_state_t state, state_next;

  logic [TW-1:0]  line_tag   [NL];
  logic [NL-1:0]  line_valid;
  logic [NL-1:0]  line_dirty;
  logic [WW-1:0]  line_rank  [NL];

  wblru_pkg::req_t cur;
  logic [LW-1:0]   line;
  logic            hit;
  logic            wrote_back;
  logic [OW:0]     cnt;
  logic [BAW:0]    clr;

  logic            c_we, b_we;
  logic [CAW-1:0]  c_wa, c_ra;
  logic [BAW-1:0]  b_wa, b_ra;
  logic [DW-1:0]   c_wd, b_wd, c_rd, b_rd;

  wblru_ram #(.WIDTH(DW), .DEPTH(CDEP)) u_lines (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );
  wblru_ram #(.WIDTH(DW), .DEPTH(BDEP)) u_store (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  // lookup on the queue head
  logic [SW-1:0] hset;
  logic [TW-1:0] htag;
  logic          lk_hit;
  logic [WW-1:0] lk_way;
  logic          found_inv;
  logic [WW-1:0] inv_way;
  logic [WW-1:0] lru;

  assign hset = SW'(q_req.set_index);
  assign htag = TW'(q_req.tag);

  always_comb begin
    lk_hit    = 1'b0;
    lk_way    = '0;
    found_inv = 1'b0;
    inv_way   = '0;
    lru       = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (line_valid[LW'(32'(hset) * WAYS + w)] &&
          line_tag[LW'(32'(hset) * WAYS + w)] == htag) begin
        lk_hit = 1'b1;
        lk_way = WW'(w);
      end
      if (!line_valid[LW'(32'(hset) * WAYS + w)]) begin
        found_inv = 1'b1;
        inv_way   = WW'(w);
      end
      if (line_rank[LW'(32'(hset) * WAYS + w)] == WW'(WAYS - 1)) begin
        lru = WW'(w);
      end
    end
  end

  logic [WW-1:0] pick_way;
  logic [LW-1:0] pick_line;
  assign pick_way  = lk_hit ? lk_way : (found_inv ? inv_way : lru);
  assign pick_line = LW'(32'(hset) * WAYS + 32'(pick_way));

  logic [SW-1:0] cset;
  logic [RW-1:0] vrow, frow;
  assign cset = SW'(cur.set_index);
  assign vrow = RW'(32'(cset) * TAGS_PER_SET + 32'(line_tag[line]));
  assign frow = RW'(32'(cset) * TAGS_PER_SET + 32'(cur.tag));

  logic [OW-1:0] rd_idx, wr_idx;
  assign rd_idx = cnt[OW-1:0];
  assign wr_idx = OW'(cnt - 1'b1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wblru_pkg::ST_CLEAR:
        if (clr == (BAW+1)'(BDEP - 1)) state_next = wblru_pkg::ST_IDLE;
      wblru_pkg::ST_IDLE:
        if (q_valid) begin
          if (lk_hit) state_next = wblru_pkg::ST_ACCESS;
          else if (line_valid[pick_line] && line_dirty[pick_line])
            state_next = wblru_pkg::ST_WB_RD;
          else state_next = wblru_pkg::ST_FILL_RD;
        end
      wblru_pkg::ST_WB_RD:
        if (cnt == (OW+1)'(WORDS_PER_LINE)) state_next = wblru_pkg::ST_FILL_RD;
      wblru_pkg::ST_FILL_RD:
        if (cnt == (OW+1)'(WORDS_PER_LINE)) state_next = wblru_pkg::ST_ACCESS;
      wblru_pkg::ST_ACCESS: state_next = wblru_pkg::ST_DONE;
      wblru_pkg::ST_DONE:   state_next = wblru_pkg::ST_IDLE;
      default:              state_next = wblru_pkg::ST_IDLE;
    endcase
  end

  // memory port controls; a copy reads word cnt and writes word cnt-1
  always_comb begin
    c_we = 1'b0;
    b_we = 1'b0;
    c_wa = CAW'(32'(line) * WORDS_PER_LINE + 32'(wr_idx));
    c_ra = CAW'(32'(line) * WORDS_PER_LINE + 32'(rd_idx));
    b_wa = BAW'(32'(vrow) * WORDS_PER_LINE + 32'(wr_idx));
    b_ra = BAW'(32'(frow) * WORDS_PER_LINE + 32'(rd_idx));
    c_wd = b_rd;
    b_wd = c_rd;
    unique case (state)
      wblru_pkg::ST_CLEAR: begin
        b_we = 1'b1;
        b_wa = clr[BAW-1:0];
        b_wd = '0;
      end
      wblru_pkg::ST_WB_RD: b_we = (cnt != '0);
      wblru_pkg::ST_FILL_RD: c_we = (cnt != '0);
      wblru_pkg::ST_ACCESS: begin
        c_ra = CAW'(32'(line) * WORDS_PER_LINE + 32'(cur.word_offset));
        c_wa = c_ra;
        c_wd = cur.write_data;
        c_we = (cur.mode == wblru_pkg::MODE_WRITE);
      end
      default: ;
    endcase
  end

  assign ready = (state == wblru_pkg::ST_IDLE);
  assign q_pop = ready && q_valid;
  assign done  = (state == wblru_pkg::ST_DONE);
  assign rsp.read_data  = (cur.mode == wblru_pkg::MODE_WRITE) ? '0 : c_rd;
  assign rsp.hit        = hit;
  assign rsp.wrote_back = wrote_back;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= q_req;
      line       <= pick_line;
      hit        <= lk_hit;
      wrote_back <= !lk_hit && line_valid[pick_line] && line_dirty[pick_line];
    end
    if (rst) begin
      state <= wblru_pkg::ST_CLEAR;
      clr   <= '0;
      cnt   <= '0;
      line_valid <= '0;
      line_dirty <= '0;
      for (int i = 0; i < NL; i++) begin
        line_tag[i]  <= '0;
        line_rank[i] <= WW'(WAYS - 1 - (i % WAYS));
      end
    end else begin
      state <= state_next;
      if (state == wblru_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (state == wblru_pkg::ST_WB_RD || state == wblru_pkg::ST_FILL_RD)
        cnt <= (cnt == (OW+1)'(WORDS_PER_LINE)) ? '0 : cnt + 1'b1;
      if (state == wblru_pkg::ST_FILL_RD && cnt == (OW+1)'(WORDS_PER_LINE)) begin
        line_tag[line]   <= TW'(cur.tag);
        line_valid[line] <= 1'b1;
        line_dirty[line] <= 1'b0;
      end
      if (state == wblru_pkg::ST_ACCESS) begin
        if (cur.mode == wblru_pkg::MODE_WRITE) line_dirty[line] <= 1'b1;
        // recency update within the set
        for (int w = 0; w < WAYS; w++) begin
          if (LW'(32'(cset) * WAYS + w) == line)
            line_rank[LW'(32'(cset) * WAYS + w)] <= '0;
          else if (line_rank[LW'(32'(cset) * WAYS + w)] < line_rank[line])
            line_rank[LW'(32'(cset) * WAYS + w)] <=
              line_rank[LW'(32'(cset) * WAYS + w)] + 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/wblru_checker.sv -----
// port-level checker for the cache, bound to the top level
// depends on wblru_pkg
`timescale 1ns / 1ps
module wblru_checker (
  input logic            clk,
  input logic            rst,
  input logic            busy,
  input logic            done,
  input wblru_pkg::rsp_t rsp
);
  a_busy_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");
  a_no_done_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beats back to back");
  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    done && rsp.hit |-> !rsp.wrote_back)
    else $error("write-back reported on a hit");
endmodule

bind write_back_lru_set_assoc_cache wblru_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .rsp(rsp)
);

// ----- tb/write_back_lru_set_assoc_cache_tb.sv -----
// self-checking testbench for the write-back lru set-associative cache
// depends on wblru_pkg and write_back_lru_set_assoc_cache; drives command beats
`timescale 1ns / 1ps
module write_back_lru_set_assoc_cache_tb;

  localparam int NSETS = 4;
  localparam int NWAYS = 2;
  localparam int NWORDS = 64;
  localparam int NTAGS = 16;
  // no-progress cycles before the watchdog fires; covers the store clear sweep
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM = 1530;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  wblru_pkg::req_t req = '0;
  wblru_pkg::rsp_t rsp;

  always #5 clk = ~clk;

  write_back_lru_set_assoc_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  // predictor state: cache lines, tags, flags, recency, backing store
  logic [31:0] cache_word [NSETS*NWAYS*NWORDS];
  logic [3:0] cache_tag [NSETS*NWAYS];
  logic cache_valid [NSETS*NWAYS];
  logic cache_dirty [NSETS*NWAYS];
  logic lru_of_set [NSETS];
  logic [31:0] store_word [NSETS*NTAGS*NWORDS];

  wblru_pkg::rsp_t expected_rsp [$];
  int errors = 0;
  int stall_cycles = 0;
  int sender_idle_pct = 23;

  // directed table; a row with known set carries a typed-in result
  typedef struct {
    wblru_pkg::req_t cmd;
    bit known;
    wblru_pkg::rsp_t rsp;
  } row_t;
  row_t directed [$];

  function automatic void model_reset();
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      cache_tag[i] = '0;
      cache_valid[i] = 1'b0;
      cache_dirty[i] = 1'b0;
    end
    for (int i = 0; i < NSETS*NWAYS*NWORDS; i++) cache_word[i] = '0;
    for (int i = 0; i < NSETS; i++) lru_of_set[i] = 1'b0;
    for (int i = 0; i < NSETS*NTAGS*NWORDS; i++) store_word[i] = '0;
  endfunction

  // compute the result of one access and update the predicted state
  function automatic wblru_pkg::rsp_t cache_access(wblru_pkg::req_t c);
    wblru_pkg::rsp_t r;
    int base;
    int way;
    int line;
    int vrow;
    int nrow;
    r = '0;
    base = c.set_index * NWAYS;
    way = -1;
    for (int w = 0; w < NWAYS; w++)
      if (way < 0 && cache_valid[base+w] && cache_tag[base+w] == c.tag) way = w;
    r.hit = (way >= 0);
    if (way < 0) begin
      for (int w = 0; w < NWAYS; w++)
        if (way < 0 && !cache_valid[base+w]) way = w;
      if (way < 0) way = int'(lru_of_set[c.set_index]);
      line = base + way;
      if (cache_valid[line] && cache_dirty[line]) begin
        vrow = c.set_index * NTAGS + cache_tag[line];
        for (int k = 0; k < NWORDS; k++)
          store_word[vrow*NWORDS+k] = cache_word[line*NWORDS+k];
        r.wrote_back = 1'b1;
      end
      nrow = c.set_index * NTAGS + c.tag;
      for (int k = 0; k < NWORDS; k++)
        cache_word[line*NWORDS+k] = store_word[nrow*NWORDS+k];
      cache_tag[line] = c.tag;
      cache_valid[line] = 1'b1;
      cache_dirty[line] = 1'b0;
    end
    line = base + way;
    if (c.mode == wblru_pkg::MODE_WRITE) begin
      cache_word[line*NWORDS+c.word_offset] = c.write_data;
      cache_dirty[line] = 1'b1;
    end else begin
      r.read_data = cache_word[line*NWORDS+c.word_offset];
    end
    // two ways: the other way becomes least recently used
    lru_of_set[c.set_index] = (way == 0);
    return r;
  endfunction

  function automatic wblru_pkg::req_t mk(logic m, int s, int t, int o, logic [31:0] d);
    wblru_pkg::req_t c;
    c.mode = m;
    c.set_index = wblru_pkg::SET_W'(s);
    c.tag = wblru_pkg::TAG_W'(t);
    c.word_offset = wblru_pkg::OFF_W'(o);
    c.write_data = d;
    return c;
  endfunction

  function automatic wblru_pkg::rsp_t rs(logic [31:0] d, logic h, logic wb);
    wblru_pkg::rsp_t r;
    r.read_data = d;
    r.hit = h;
    r.wrote_back = wb;
    return r;
  endfunction

  function automatic void add_row(wblru_pkg::req_t c, bit k, wblru_pkg::rsp_t r);
    row_t x;
    x.cmd = c;
    x.known = k;
    x.rsp = r;
    directed = {directed, x};
  endfunction

  // result checking at each strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result beat: read_data %h", rsp.read_data);
        errors++;
      end else begin
        wblru_pkg::rsp_t e;
        e = expected_rsp.pop_front();
        if (rsp.read_data !== e.read_data) begin
          $error("read_data expected %h actual %h", e.read_data, rsp.read_data);
          errors++;
        end
        if (rsp.hit !== e.hit) begin
          $error("hit expected %b actual %b", e.hit, rsp.hit);
          errors++;
        end
        if (rsp.wrote_back !== e.wrote_back) begin
          $error("wrote_back expected %b actual %b", e.wrote_back, rsp.wrote_back);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat of either kind
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("write_back_lru_set_assoc_cache verification failed");
      $finish;
    end
  end

  // send one command beat, holding start until accepted; start stays high
  // after the beat so the next one can follow at once
  task automatic send(wblru_pkg::req_t c, bit known, wblru_pkg::rsp_t r);
    wblru_pkg::rsp_t p;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = cache_access(c);
    if (known && p !== r) begin
      $error("directed row mismatch: table %h predictor %h", r, p);
      errors++;
    end
    if (known) p = r;
    expected_rsp = {expected_rsp, p};
  endtask

  // random command with a tendency to hit a small working set
  function automatic wblru_pkg::req_t rand_cmd();
    int s;
    int t;
    s = $urandom_range(NSETS-1);
    t = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(NTAGS-1);
    return mk(1'($urandom_range(1)), s, t,
              ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(NWORDS-1),
              $urandom());
  endfunction

  initial begin
    int drained;
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // a fresh miss reads zero from the cleared store, and so does the hit after it
    add_row(mk(wblru_pkg::MODE_READ, 0, 0, 0, 0), 1'b1, rs(32'h0, 1'b0, 1'b0));
    add_row(mk(wblru_pkg::MODE_READ, 0, 0, 63, 0), 1'b1, rs(32'h0, 1'b1, 1'b0));
    // extreme data written then read back
    add_row(mk(wblru_pkg::MODE_WRITE, 0, 0, 63, 32'h8000_0000), 1'b1,
            rs(32'h0, 1'b1, 1'b0));
    add_row(mk(wblru_pkg::MODE_READ, 0, 0, 63, 32'hffff_ffff), 1'b1,
            rs(32'h8000_0000, 1'b1, 1'b0));
    add_row(mk(wblru_pkg::MODE_WRITE, 3, 15, 0, 32'h7fff_ffff), 1'b1,
            rs(32'h0, 1'b0, 1'b0));
    add_row(mk(wblru_pkg::MODE_READ, 3, 15, 0, 0), 1'b1, rs(32'h7fff_ffff, 1'b1, 1'b0));
    add_row(mk(wblru_pkg::MODE_WRITE, 3, 15, 1, 32'hffff_ffff), 1'b0, '0);
    // fill second way of set 0, then evict the dirty lru line
    add_row(mk(wblru_pkg::MODE_READ, 0, 1, 5, 0), 1'b1, rs(32'h0, 1'b0, 1'b0));
    add_row(mk(wblru_pkg::MODE_READ, 0, 2, 5, 0), 1'b1, rs(32'h0, 1'b0, 1'b1));
    // old dirty line comes back from the store
    add_row(mk(wblru_pkg::MODE_READ, 0, 0, 63, 0), 1'b1, rs(32'h8000_0000, 1'b0, 1'b0));
    // clean victim: no write-back
    add_row(mk(wblru_pkg::MODE_READ, 0, 3, 2, 0), 1'b1, rs(32'h0, 1'b0, 1'b0));
    add_row(mk(wblru_pkg::MODE_WRITE, 3, 14, 62, 32'h1234_5678), 1'b0, '0);
    add_row(mk(wblru_pkg::MODE_READ, 3, 13, 62, 0), 1'b0, '0);
    add_row(mk(wblru_pkg::MODE_READ, 3, 15, 1, 0), 1'b0, '0);
    add_row(mk(wblru_pkg::MODE_WRITE, 1, 9, 31, 32'h5555_aaaa), 1'b0, '0);
    add_row(mk(wblru_pkg::MODE_WRITE, 2, 6, 32, 32'haaaa_5555), 1'b0, '0);
    add_row(mk(wblru_pkg::MODE_READ, 2, 6, 32, 0), 1'b0, '0);
    foreach (directed[i]) send(directed[i].cmd, directed[i].known, directed[i].rsp);
    start <= 1'b0;

    // pause until everything directed has come back
    while (expected_rsp.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM/3) sender_idle_pct = 63;
      if (i == 2*N_RANDOM/3) sender_idle_pct = 0;
      send(rand_cmd(), 1'b0, '0);
    end
    start <= 1'b0;

    drained = 0;
    while (expected_rsp.size() != 0 && drained < STALL_LIMIT) begin
      @(posedge clk);
      drained++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("write_back_lru_set_assoc_cache verification clean");
    end else begin
      $display("write_back_lru_set_assoc_cache verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/wblru_pkg.sv
src/wblru_ram.sv
src/wblru_front.sv
src/wblru_back.sv
src/write_back_lru_set_assoc_cache.sv
src/wblru_checker.sv
tb/write_back_lru_set_assoc_cache_tb.sv
